// ----- sv/spta_pkg.sv -----
// Shared types and codes for the sparse polynomial term accumulator.
// Depends on nothing; every other file of the block imports it.
package spta_pkg;

  localparam int COEF_BITS = 32;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_MERGED     = 3'd1,
    ST_CANCELLED  = 3'd2,
    ST_FULL       = 3'd3,
    ST_ZERO       = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_READ_EMPTY = 3'd6,
    ST_CLEARED    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } fsm_t;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_MERGE,
    CO_INSERT,
    CO_REMOVE
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t             op;
    logic                 acc;
    logic [COEF_BITS-1:0] coef;
  } cell_ctl_t;

endpackage

// ----- sv/sparse_poly_term_accumulator.sv -----
// Sparse polynomial term accumulator: a chain of term cells kept sorted by
// descending power. A word passes an evaluate state, in which every cell
// compares its power and the matched term is gathered into a register, and
// a commit state, in which the shared saturating adder runs, the chain
// shifts and the result is registered; commit waits while a result is
// untaken. A new word is accepted when idle or as the last one commits.
// Reset empties the held count; the cells themselves are not cleared.
module sparse_poly_term_accumulator #(
  parameter int MAX_TERMS  = 64,
  parameter int POWER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic signed [31:0]    coef,
  input  logic [15:0]           exponent,
  input  logic [5:0]            rank,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spta_pkg::status_t     status,
  output logic signed [31:0]    out_coef,
  output logic [15:0]           out_exponent,
  output logic [6:0]            term_count,
  output logic                  saturated
);
  import spta_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int SW = (POWER_BITS < 16) ? POWER_BITS : 16;

  fsm_t state, state_next;

  logic [1:0]           cmd_r;
  logic [COEF_BITS-1:0] coef_r;
  logic [SW-1:0]        pw_r;
  logic [5:0]           rank_r;

  logic [CW-1:0]        held, held_next;
  logic                 hit;
  logic [COEF_BITS-1:0] hit_coef;
  logic [SW-1:0]        hit_pow;

  logic                 in_acc;
  logic                 can_commit;
  logic                 commit;
  cell_ctl_t            ctl;
  cell_op_t             op;

  status_t              res_status;
  logic [COEF_BITS-1:0] res_coef;
  logic [SW-1:0]        res_pow;
  logic                 res_sat;
  logic [SW+15:0]       res_pow_ext;
  logic [CW+6:0]        held_ext;

  logic [COEF_BITS-1:0] sum;
  logic                 sum_sat;

  logic [COEF_BITS-1:0] c_coef [MAX_TERMS];
  logic [SW-1:0]        c_pow  [MAX_TERMS];
  logic                 c_gt   [MAX_TERMS];
  logic                 c_sel  [MAX_TERMS];

  logic                 red_hit;
  logic [COEF_BITS-1:0] red_coef;
  logic [SW-1:0]        red_pow;

  assign in_acc     = in_valid && in_ready;
  assign can_commit = !out_valid || out_ready;
  assign commit     = (state == S_COMMIT) && can_commit;
  assign in_ready   = (state == S_IDLE) || commit;

  // ---------------- cell chain ----------------
  assign ctl.op   = commit ? op : CO_HOLD;
  assign ctl.acc  = (cmd_r == CMD_ACC);
  assign ctl.coef = (op == CO_MERGE) ? sum : coef_r;

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    logic                 pgt;
    logic [COEF_BITS-1:0] lc, rc;
    logic [SW-1:0]        lp, rp;

    if (g == 0) begin : g_first
      assign pgt = 1'b1;
      assign lc  = '0;
      assign lp  = '0;
    end else begin : g_mid
      assign pgt = c_gt[g-1];
      assign lc  = c_coef[g-1];
      assign lp  = c_pow[g-1];
    end

    if (g == MAX_TERMS - 1) begin : g_last
      assign rc = c_coef[g];
      assign rp = c_pow[g];
    end else begin : g_inner
      assign rc = c_coef[g+1];
      assign rp = c_pow[g+1];
    end

    spta_cell #(
      .IDX (g),
      .CW  (CW),
      .SW  (SW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .held       (held),
      .pw         (pw_r),
      .rank       (rank_r),
      .prev_gt    (pgt),
      .left_coef  (lc),
      .left_pow   (lp),
      .right_coef (rc),
      .right_pow  (rp),
      .gt         (c_gt[g]),
      .sel        (c_sel[g]),
      .coef       (c_coef[g]),
      .pow        (c_pow[g])
    );
  end

  // At most one cell is selected, so an OR gathers its term.
  always_comb begin
    red_hit  = 1'b0;
    red_coef = '0;
    red_pow  = '0;
    for (int i = 0; i < MAX_TERMS; i++) begin
      red_hit  = red_hit | c_sel[i];
      red_coef = red_coef | (c_coef[i] & {COEF_BITS{c_sel[i]}});
      red_pow  = red_pow | (c_pow[i] & {SW{c_sel[i]}});
    end
  end

  spta_sat_add u_add (
    .a   (hit_coef),
    .b   (coef_r),
    .sum (sum),
    .sat (sum_sat)
  );

  // ---------------- commit decision ----------------
  always_comb begin
    op         = CO_HOLD;
    held_next  = held;
    res_status = ST_READ_EMPTY;
    res_coef   = '0;
    res_pow    = '0;
    res_sat    = 1'b0;
    priority if (cmd_r == CMD_CLEAR) begin
      held_next  = '0;
      res_status = ST_CLEARED;
    end else if (cmd_r != CMD_ACC) begin
      if (hit) begin
        res_status = ST_READ_OK;
        res_coef   = hit_coef;
        res_pow    = hit_pow;
      end
    end else if (coef_r == '0) begin
      res_status = ST_ZERO;
      res_pow    = pw_r;
    end else if (hit) begin
      res_pow = pw_r;
      if (sum == '0) begin
        op         = CO_REMOVE;
        held_next  = held - 1'b1;
        res_status = ST_CANCELLED;
      end else begin
        op         = CO_MERGE;
        res_status = ST_MERGED;
        res_coef   = sum;
        res_sat    = sum_sat;
      end
    end else if (held == CW'(MAX_TERMS)) begin
      res_status = ST_FULL;
      res_coef   = coef_r;
      res_pow    = pw_r;
    end else begin
      op         = CO_INSERT;
      held_next  = held + 1'b1;
      res_status = ST_INSERTED;
      res_coef   = coef_r;
      res_pow    = pw_r;
    end
  end

  assign res_pow_ext = {16'b0, res_pow};
  assign held_ext    = {7'b0, held_next};

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) begin
          state_next = in_acc ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= command;
      coef_r <= coef;
      pw_r   <= exponent[SW-1:0];
      rank_r <= rank;
    end
    if (state == S_EVAL) begin
      hit      <= red_hit;
      hit_coef <= red_coef;
      hit_pow  <= red_pow;
    end
    if (commit) begin
      status       <= res_status;
      out_coef     <= res_coef;
      out_exponent <= res_pow_ext[15:0];
      term_count   <= held_ext[6:0];
      saturated    <= res_sat;
    end
  end

  // ---------------- checks ----------------
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(MAX_TERMS))
    else $error("held count beyond table size");

  a_eval_to_commit: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |=> state == S_COMMIT)
    else $error("evaluate cycle not followed by commit");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_EVAL)
    else $error("accepted word did not enter evaluation");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_COMMIT)
    else $error("result appeared without a commit");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (commit && op == CO_INSERT) |=> held == CW'($past(held) + 1'b1))
    else $error("insert did not grow the held count");

endmodule

// ----- sv/spta_cell.sv -----
// One term cell of the sorted chain: holds a coefficient and a power.
// Depends on spta_pkg; its neighbours supply shift data in both directions.
module spta_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int SW  = 16
) (
  input  logic                           clk,
  input  spta_pkg::cell_ctl_t            ctl,
  input  logic [CW-1:0]                  held,
  input  logic [SW-1:0]                  pw,
  input  logic [5:0]                     rank,
  input  logic                           prev_gt,
  input  logic [spta_pkg::COEF_BITS-1:0] left_coef,
  input  logic [SW-1:0]                  left_pow,
  input  logic [spta_pkg::COEF_BITS-1:0] right_coef,
  input  logic [SW-1:0]                  right_pow,
  output logic                           gt,
  output logic                           sel,
  output logic [spta_pkg::COEF_BITS-1:0] coef,
  output logic [SW-1:0]                  pow
);
  import spta_pkg::*;

  logic valid;
  logic eq;
  logic rank_hit;

  // Entries below the held count are the live terms.
  assign valid    = held > CW'(IDX);
  assign gt       = valid && (pow > pw);
  assign eq       = valid && (pow == pw);
  assign rank_hit = valid && (32'(rank) == IDX);
  assign sel      = ctl.acc ? eq : rank_hit;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CO_MERGE: begin
        if (eq) begin
          coef <= ctl.coef;
        end
      end
      CO_INSERT: begin
        // The first cell whose power is not above the new one takes the new
        // term; every cell after it takes its left neighbour's word.
        if (!gt) begin
          if (prev_gt) begin
            coef <= ctl.coef;
            pow  <= pw;
          end else begin
            coef <= left_coef;
            pow  <= left_pow;
          end
        end
      end
      CO_REMOVE: begin
        if (!gt) begin
          coef <= right_coef;
          pow  <= right_pow;
        end
      end
      CO_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/spta_sat_add.sv -----
// Shared saturating adder for Q16.16 coefficients.
// Depends on spta_pkg for the coefficient width.
module spta_sat_add (
  input  logic [spta_pkg::COEF_BITS-1:0] a,
  input  logic [spta_pkg::COEF_BITS-1:0] b,
  output logic [spta_pkg::COEF_BITS-1:0] sum,
  output logic                           sat
);
  import spta_pkg::*;

  logic [COEF_BITS:0] wide;

  assign wide = {a[COEF_BITS-1], a} + {b[COEF_BITS-1], b};
  // The two top bits differ only when the exact sum left the 32-bit range.
  assign sat  = wide[COEF_BITS] ^ wide[COEF_BITS-1];

  always_comb begin
    if (!sat) begin
      sum = wide[COEF_BITS-1:0];
    end else if (wide[COEF_BITS]) begin
      sum = {1'b1, {(COEF_BITS-1){1'b0}}};
    end else begin
      sum = {1'b0, {(COEF_BITS-1){1'b1}}};
    end
  end

endmodule
